[design/gjd_pkg.sv]
// Shared constants, types and calendar tables of the Gregorian / Julian day converter.
package gjd_pkg;

    localparam logic [22:0] FIRST_JDN    = 23'd2361331;
    localparam logic [22:0] LAST_JDN     = 23'd5373484;
    localparam logic [22:0] EPOCH_OFFSET = 23'd1721119;
    localparam logic [13:0] MIN_YEAR     = 14'd1753;
    localparam logic [13:0] MAX_YEAR     = 14'd9999;

    typedef struct packed {
        logic        valid;
        logic        ok;
        logic [22:0] jdn;
    } gjd_day_t;

    function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
        logic [4:0] n;
        case (m)
            4'd2:                      n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
        logic [8:0] s;
        case (m)
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        if (leap && m > 4'd2)
        begin
            s = s + 9'd1;
        end
        return s;
    endfunction

    // Days from 1 March to the first of a March-based month.
    function automatic logic [8:0] march_offset(input logic [3:0] mm);
        logic [8:0] s;
        case (mm)
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    // Leap rule from the year, its remainder by 100 and its quotient by 100.
    function automatic logic leap_rule(input logic [13:0] y, input logic [6:0] r100,
                                       input logic [7:0] q100);
        logic by4000;
        by4000 = (y == 14'd0) || (y == 14'd4000) || (y == 14'd8000) ||
                 (y == 14'd12000) || (y == 14'd16000);
        return ((y[1:0] == 2'd0) && (r100 != 7'd0)) ||
               ((r100 == 7'd0) && (q100[1:0] == 2'd0) && !by4000);
    endfunction

endpackage

[design/gjd_date_front.sv]
// Input stages: date check, Julian day number range check and date to Julian day number, four register stages.
module gjd_date_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic             command,
    input  logic [13:0]      year_in,
    input  logic [3:0]       month_in,
    input  logic [4:0]       day_in,
    input  logic [22:0]      day_number_in,
    output gjd_pkg::gjd_day_t day_out
);
    import gjd_pkg::*;

    logic [3:0]  v_reg, v_next;

    logic        s1_cmd_reg, s1_mok_reg;
    logic [13:0] s1_y_reg, s1_ym_reg;
    logic [3:0]  s1_m_reg, s1_mm_reg;
    logic [4:0]  s1_d_reg;
    logic [22:0] s1_dn_reg;
    logic [7:0]  s1_q_reg, s1_c_reg;

    logic        s2_cmd_reg, s2_mok_reg;
    logic [13:0] s2_y_reg;
    logic [3:0]  s2_m_reg;
    logic [4:0]  s2_d_reg;
    logic [22:0] s2_dn_reg;
    logic [7:0]  s2_q_reg;
    logic [6:0]  s2_r100_reg, s2_ya_reg;
    logic [24:0] s2_p1_reg;
    logic [8:0]  s2_t3_reg;

    logic        s3_cmd_reg, s3_ok_reg;
    logic [4:0]  s3_d_reg;
    logic [22:0] s3_dn_reg;
    logic [24:0] s3_p1_reg;
    logic [17:0] s3_p2_reg;
    logic [8:0]  s3_t3_reg;

    logic        s4_ok_reg;
    logic [22:0] s4_jdn_reg;

    logic [26:0] mq, mc;
    logic [13:0] ym;
    logic [3:0]  mm;
    logic        mok;
    logic [13:0] r100_full, ya_full;
    logic [25:0] p1_full;
    logic        leap, dok, jok;
    logic [23:0] sum;

    always_comb
    begin
        mq  = 27'(year_in) * 27'd5243;
        ym  = (month_in > 4'd2) ? year_in : year_in - 14'd1;
        mm  = (month_in > 4'd2) ? month_in - 4'd3 : month_in + 4'd9;
        mc  = 27'(ym) * 27'd5243;
        mok = (month_in >= 4'd1) && (month_in <= 4'd12) && (day_in >= 5'd1) &&
              (year_in >= MIN_YEAR) && (year_in <= MAX_YEAR);

        r100_full = s1_y_reg - 14'(s1_q_reg) * 14'd100;
        ya_full   = s1_ym_reg - 14'(s1_c_reg) * 14'd100;
        p1_full   = 26'(s1_c_reg) * 26'd146097;

        leap = leap_rule(s2_y_reg, s2_r100_reg, s2_q_reg);
        dok  = s2_mok_reg && (s2_d_reg <= month_days(leap, s2_m_reg));
        jok  = (s2_dn_reg >= FIRST_JDN) && (s2_dn_reg <= LAST_JDN);

        sum = 24'(s3_p1_reg[24:2]) + 24'(s3_p2_reg[17:2]) + 24'(s3_t3_reg) +
              24'(s3_d_reg) + 24'(EPOCH_OFFSET);

        v_next = {v_reg[2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg <= command;
            s1_mok_reg <= mok;
            s1_y_reg   <= year_in;
            s1_ym_reg  <= ym;
            s1_m_reg   <= month_in;
            s1_mm_reg  <= mm;
            s1_d_reg   <= day_in;
            s1_dn_reg  <= day_number_in;
            s1_q_reg   <= mq[26:19];
            s1_c_reg   <= mc[26:19];

            s2_cmd_reg  <= s1_cmd_reg;
            s2_mok_reg  <= s1_mok_reg;
            s2_y_reg    <= s1_y_reg;
            s2_m_reg    <= s1_m_reg;
            s2_d_reg    <= s1_d_reg;
            s2_dn_reg   <= s1_dn_reg;
            s2_q_reg    <= s1_q_reg;
            s2_r100_reg <= r100_full[6:0];
            s2_ya_reg   <= ya_full[6:0];
            s2_p1_reg   <= p1_full[24:0];
            s2_t3_reg   <= march_offset(s1_mm_reg);

            s3_cmd_reg <= s2_cmd_reg;
            s3_ok_reg  <= s2_cmd_reg ? jok : dok;
            s3_d_reg   <= s2_d_reg;
            s3_dn_reg  <= s2_dn_reg;
            s3_p1_reg  <= s2_p1_reg;
            s3_p2_reg  <= 18'(s2_ya_reg) * 18'd1461;
            s3_t3_reg  <= s2_t3_reg;

            s4_ok_reg  <= s3_ok_reg;
            s4_jdn_reg <= !s3_ok_reg ? FIRST_JDN : (s3_cmd_reg ? s3_dn_reg : sum[22:0]);
        end
    end

    assign day_out = '{valid: v_reg[3], ok: s4_ok_reg, jdn: s4_jdn_reg};

endmodule

[design/gjd_date_split.sv]
// Julian day number to Gregorian date and weekday, nine register stages.
module gjd_date_split (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  gjd_pkg::gjd_day_t day_in,
    output gjd_pkg::gjd_day_t day_out,
    output logic [2:0]        wd_out,
    output logic [13:0]       y_out,
    output logic [3:0]        m_out,
    output logic [4:0]        d_out
);
    import gjd_pkg::*;

    logic [8:0]  pv_reg;
    logic [8:0]  pok_reg;
    logic [22:0] pjdn_reg [9];

    logic [23:0] b1_x_reg;
    logic [6:0]  b1_qa_reg;
    logic [19:0] b1_q7_reg;
    logic [18:0] b2_r_reg;
    logic [6:0]  b2_qa_reg;
    logic [3:0]  b2_wr_reg;
    logic [6:0]  b3_cy_reg;
    logic [17:0] b3_v_reg;
    logic [2:0]  wd_reg [3:9];
    logic [6:0]  cy_reg [4:8];
    logic [17:0] b4_v_reg;
    logic [6:0]  b4_qy_reg;
    logic [11:0] b5_r2_reg;
    logic [6:0]  b5_qy_reg;
    logic [6:0]  b6_yy_reg;
    logic [10:0] b6_w_reg;
    logic [6:0]  b7_yy_reg;
    logic [10:0] b7_w_reg;
    logic [3:0]  b7_qm_reg;
    logic [6:0]  b8_yy_reg;
    logic [8:0]  b8_r3_reg;
    logic [3:0]  b8_qm_reg;
    logic [13:0] b9_y_reg;
    logic [3:0]  b9_m_reg;
    logic [4:0]  b9_d_reg;

    logic [22:0] jm;
    logic [23:0] x;
    logic [37:0] pa;
    logic [45:0] p7;
    logic [24:0] rf;
    logic [22:0] wf;
    logic        ge1, ge2, ge3;
    logic [17:0] t;
    logic [34:0] py;
    logic [17:0] r2f;
    logic [10:0] r2c;
    logic [11:0] dd2;
    logic [10:0] w;
    logic [19:0] pm;
    logic [10:0] r3f;
    logic [7:0]  r3c;
    logic [3:0]  mm;
    logic [15:0] dq;
    logic [13:0] yf;

    always_comb
    begin
        jm = day_in.jdn - EPOCH_OFFSET;
        x  = {jm[21:0], 2'b00} - 24'd1;
        pa = 38'(x) * 38'd14699;
        p7 = 46'(day_in.jdn) * 46'd9586980;

        rf = 25'(b1_x_reg) - 25'(b1_qa_reg) * 25'd146097;
        wf = pjdn_reg[0] - 23'(b1_q7_reg) * 23'd7;

        ge1 = b2_r_reg >= 19'd146097;
        t   = ge1 ? 18'(b2_r_reg - 19'd146097) : b2_r_reg[17:0];

        py  = 35'(b3_v_reg) * 35'd91867;
        r2f = b4_v_reg - 18'(b4_qy_reg) * 18'd1461;

        ge2 = b5_r2_reg >= 12'd1461;
        r2c = ge2 ? 11'(b5_r2_reg - 12'd1461) : b5_r2_reg[10:0];
        dd2 = (12'(r2c) + 12'd4) >> 2;
        w   = 11'(dd2) * 11'd5 - 11'd3;

        pm  = 20'(b6_w_reg) * 20'd428;
        r3f = b7_w_reg - 11'(b7_qm_reg) * 11'd153;

        ge3 = b8_r3_reg >= 9'd153;
        r3c = ge3 ? 8'(b8_r3_reg - 9'd153) : b8_r3_reg[7:0];
        mm  = b8_qm_reg + 4'(ge3);
        dq  = (16'(r3c) + 16'd5) * 16'd205;
        yf  = 14'(cy_reg[8]) * 14'd100 + 14'(b8_yy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
        end
        else if (adv)
        begin
            pv_reg <= {pv_reg[7:0], day_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pok_reg     <= {pok_reg[7:0], day_in.ok};
            pjdn_reg[0] <= day_in.jdn;
            for (int i = 1; i < 9; i++)
            begin
                pjdn_reg[i] <= pjdn_reg[i-1];
            end

            b1_x_reg  <= x;
            b1_qa_reg <= pa[37:31];
            b1_q7_reg <= p7[45:26];

            b2_r_reg  <= rf[18:0];
            b2_qa_reg <= b1_qa_reg;
            b2_wr_reg <= wf[3:0];

            b3_cy_reg <= b2_qa_reg + 7'(ge1);
            b3_v_reg  <= {t[17:2], 2'b11};
            wd_reg[3] <= (b2_wr_reg >= 4'd7) ? 3'(b2_wr_reg - 4'd7) : b2_wr_reg[2:0];
            for (int i = 4; i < 10; i++)
            begin
                wd_reg[i] <= wd_reg[i-1];
            end

            cy_reg[4] <= b3_cy_reg;
            for (int i = 5; i < 9; i++)
            begin
                cy_reg[i] <= cy_reg[i-1];
            end

            b4_v_reg  <= b3_v_reg;
            b4_qy_reg <= py[33:27];

            b5_r2_reg <= r2f[11:0];
            b5_qy_reg <= b4_qy_reg;

            b6_yy_reg <= b5_qy_reg + 7'(ge2);
            b6_w_reg  <= w;

            b7_yy_reg <= b6_yy_reg;
            b7_w_reg  <= b6_w_reg;
            b7_qm_reg <= pm[19:16];

            b8_yy_reg <= b7_yy_reg;
            b8_r3_reg <= r3f[8:0];
            b8_qm_reg <= b7_qm_reg;

            b9_d_reg <= dq[14:10];
            if (mm < 4'd10)
            begin
                b9_m_reg <= mm + 4'd3;
                b9_y_reg <= yf;
            end
            else
            begin
                b9_m_reg <= mm - 4'd9;
                b9_y_reg <= yf + 14'd1;
            end
        end
    end

    assign day_out = '{valid: pv_reg[8], ok: pok_reg[8], jdn: pjdn_reg[8]};
    assign wd_out  = wd_reg[9];
    assign y_out   = b9_y_reg;
    assign m_out   = b9_m_reg;
    assign d_out   = b9_d_reg;

endmodule

[design/gregorian_julian_day_converter_unit.sv]
// Top level of the Gregorian date / Julian day number converter.
// An item is a date (command 0) or a Julian day number (command 1); each item gives one
// result with both forms of the day, weekday, day of year, month length and leap flag.
// The block is a 16-stage pipeline that takes one item every cycle while in_stall is low.
// The whole pipeline holds while a result waits at the output, so in_stall follows
// out_stall in the same cycle. Illegal input gives 1 Jan 1753 with valid_res low.
module gregorian_julian_day_converter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [13:0] year_in,
    input  logic [3:0]  month_in,
    input  logic [4:0]  day_in,
    input  logic [22:0] day_number_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [22:0] day_number,
    output logic [13:0] year_out,
    output logic [3:0]  month_out,
    output logic [4:0]  day_out,
    output logic [2:0]  weekday,
    output logic [8:0]  day_of_year,
    output logic [4:0]  month_length,
    output logic        leap_year,
    output logic        valid_res
);
    import gjd_pkg::*;

    logic        adv;
    gjd_day_t    front_day, split_day;
    logic [2:0]  split_wd;
    logic [13:0] split_y;
    logic [3:0]  split_m;
    logic [4:0]  split_d;

    logic        t1_valid_reg, t2_valid_reg;
    logic        t1_ok_reg, t2_ok_reg;
    logic [22:0] t1_jdn_reg, t2_jdn_reg;
    logic [2:0]  t1_wd_reg, t2_wd_reg;
    logic [13:0] t1_y_reg, t2_y_reg;
    logic [3:0]  t1_m_reg, t2_m_reg;
    logic [4:0]  t1_d_reg, t2_d_reg;
    logic [7:0]  t1_q_reg;
    logic        t2_leap_reg;

    logic        out_valid_reg;
    logic        out_ok_reg, out_leap_reg;
    logic [22:0] out_jdn_reg;
    logic [13:0] out_y_reg;
    logic [3:0]  out_m_reg;
    logic [4:0]  out_d_reg, out_len_reg;
    logic [2:0]  out_wd_reg;
    logic [8:0]  out_doy_reg;

    logic [26:0] yq;
    logic [13:0] r100_full;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    gjd_date_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (in_valid),
        .command       (command),
        .year_in       (year_in),
        .month_in      (month_in),
        .day_in        (day_in),
        .day_number_in (day_number_in),
        .day_out       (front_day)
    );

    gjd_date_split u_split (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .day_in  (front_day),
        .day_out (split_day),
        .wd_out  (split_wd),
        .y_out   (split_y),
        .m_out   (split_m),
        .d_out   (split_d)
    );

    always_comb
    begin
        yq        = 27'(split_y) * 27'd5243;
        r100_full = t1_y_reg - 14'(t1_q_reg) * 14'd100;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg  <= 1'b0;
            t2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t1_valid_reg  <= split_day.valid;
            t2_valid_reg  <= t1_valid_reg;
            out_valid_reg <= t2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_ok_reg  <= split_day.ok;
            t1_jdn_reg <= split_day.jdn;
            t1_wd_reg  <= split_wd;
            t1_y_reg   <= split_y;
            t1_m_reg   <= split_m;
            t1_d_reg   <= split_d;
            t1_q_reg   <= yq[26:19];

            t2_ok_reg   <= t1_ok_reg;
            t2_jdn_reg  <= t1_jdn_reg;
            t2_wd_reg   <= t1_wd_reg;
            t2_y_reg    <= t1_y_reg;
            t2_m_reg    <= t1_m_reg;
            t2_d_reg    <= t1_d_reg;
            t2_leap_reg <= leap_rule(t1_y_reg, r100_full[6:0], t1_q_reg);

            out_ok_reg   <= t2_ok_reg;
            out_jdn_reg  <= t2_jdn_reg;
            out_wd_reg   <= t2_wd_reg;
            out_y_reg    <= t2_y_reg;
            out_m_reg    <= t2_m_reg;
            out_d_reg    <= t2_d_reg;
            out_leap_reg <= t2_leap_reg;
            out_len_reg  <= month_days(t2_leap_reg, t2_m_reg);
            out_doy_reg  <= month_start(t2_leap_reg, t2_m_reg) + 9'(t2_d_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign day_number   = out_jdn_reg;
    assign year_out     = out_y_reg;
    assign month_out    = out_m_reg;
    assign day_out      = out_d_reg;
    assign weekday      = out_wd_reg;
    assign day_of_year  = out_doy_reg;
    assign month_length = out_len_reg;
    assign leap_year    = out_leap_reg;
    assign valid_res    = out_ok_reg;

endmodule

[design/gjd_checker.sv]
// Port-level checker for the converter and the bind that attaches it.
module gjd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [22:0] day_number,
    input logic [13:0] year_out,
    input logic [3:0]  month_out,
    input logic [2:0]  weekday,
    input logic        valid_res
);
    import gjd_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("A stalled result was dropped.");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("The input stalled with no result held at the output.");

    a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> day_number == FIRST_JDN && year_out == MIN_YEAR)
        else $error("An illegal item did not give 1 Jan 1753.");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> month_out >= 4'd1 && month_out <= 4'd12 && weekday <= 3'd6 &&
                      day_number >= FIRST_JDN && day_number <= LAST_JDN)
        else $error("A result field is out of its range.");

endmodule

bind gregorian_julian_day_converter_unit gjd_checker u_gjd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .day_number (day_number),
    .year_out   (year_out),
    .month_out  (month_out),
    .weekday    (weekday),
    .valid_res  (valid_res)
);
